>>> rtl/core/lfe_pkg.sv
// Shared types, constants and helper functions for the line following error block.
package lfe_pkg;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } lfe_in_t;

  typedef struct packed {
    logic signed [31:0] along_error;
    logic signed [31:0] lateral_error;
    logic signed [15:0] heading_error;
    logic               degenerate;
  } lfe_out_t;

  localparam int DiffW = 33;
  localparam int ProdW = 66;
  localparam int SumW  = 67;
  localparam int RootW = 33;
  localparam int AngW  = 20;
  localparam int CordW = 44;
  localparam int ZW    = 34;
  localparam int CordicIters = 30;

  localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] PiHalfQ30 = 34'sd1686629713;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314857;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525159;
      4:  r = 30'd67021687;
      5:  r = 30'd33543516;
      6:  r = 30'd16775851;
      7:  r = 30'd8388437;
      8:  r = 30'd4194283;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      24: r = 30'd63;
      25: r = 30'd31;
      26: r = 30'd15;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int pi_q(input int af);
    longint t;
    t = (64'sd3373259426 + (64'sd1 <<< (29 - af))) >>> (30 - af);
    return int'(t);
  endfunction

  function automatic int wrap_ks(input int af);
    return 21 - $clog2(2 * pi_q(af));
  endfunction

endpackage

>>> rtl/core/lfe_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module lfe_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lfe_pkg::ProdW-1:0]    n_i,
  output logic [lfe_pkg::RootW-1:0]    root_o
);

  localparam int NS = lfe_pkg::RootW;
  localparam int W  = lfe_pkg::SumW;

  logic [W-1:0] num_q [NS];
  logic [W-1:0] res_q [NS];
  logic [W-1:0] num_p [NS];
  logic [W-1:0] res_p [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [W-1:0] bitv;
    logic [W-1:0] trial;
    if (j == 0) begin : g_first
      assign num_p[j] = {1'b0, n_i};
      assign res_p[j] = '0;
    end else begin : g_next
      assign num_p[j] = num_q[j-1];
      assign res_p[j] = res_q[j-1];
    end
    assign bitv  = W'(1) << (2 * (NS - 1 - j));
    assign trial = res_p[j] + bitv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (num_p[j] >= trial) begin
          num_q[j] <= num_p[j] - trial;
          res_q[j] <= (res_p[j] >> 1) + bitv;
        end else begin
          num_q[j] <= num_p[j];
          res_q[j] <= res_p[j] >> 1;
        end
      end
    end
  end

  assign root_o = res_q[NS-1][NS-1:0];

endmodule

>>> rtl/core/lfe_div.sv
// Pipelined signed divide by the segment length with 32-bit saturation.
module lfe_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lfe_pkg::SumW-1:0]   n_i,
  input  logic        [lfe_pkg::RootW-1:0]  d_i,
  output logic signed [31:0]                q_o
);

  localparam int W  = lfe_pkg::SumW;
  localparam int QB = lfe_pkg::RootW;

  logic          neg_a_q;
  logic [W-1:0]  mag_a_q;
  logic [QB-1:0] d_a_q;

  logic [W-1:0]  rem_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [QB-1:0] dv_q  [QB+1];
  logic          neg_q [QB+1];
  logic          big_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= n_i[W-1];
      mag_a_q  <= n_i[W-1] ? W'(-n_i) : W'(n_i);
      d_a_q    <= d_i;
      rem_q[0] <= mag_a_q;
      quo_q[0] <= '0;
      dv_q[0]  <= d_a_q;
      neg_q[0] <= neg_a_q;
      big_q[0] <= mag_a_q >= (W'(d_a_q) << QB);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [W-1:0] sh;
    logic         hit;
    assign sh  = W'(dv_q[j]) << (QB - 1 - j);
    assign hit = rem_q[j] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= hit ? rem_q[j] - sh : rem_q[j];
        quo_q[j+1] <= quo_q[j] | (QB'(hit) << (QB - 1 - j));
        dv_q[j+1]  <= dv_q[j];
        neg_q[j+1] <= neg_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  logic [QB-1:0]    qf;
  logic signed [31:0] q_d;
  logic signed [31:0] q_q;

  always_comb begin
    qf = quo_q[QB];
    if (neg_q[QB]) begin
      if (big_q[QB] || qf > QB'(33'h080000000)) q_d = 32'sh80000000;
      else q_d = -$signed(qf[31:0]);
    end else begin
      if (big_q[QB] || qf > QB'(33'h07FFFFFFF)) q_d = 32'sh7FFFFFFF;
      else q_d = $signed(qf[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

>>> rtl/core/lfe_cordic.sv
// Pipelined CORDIC vectoring unit giving the segment direction angle.
module lfe_cordic #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [lfe_pkg::DiffW-1:0]   x_i,
  input  logic signed [lfe_pkg::DiffW-1:0]   y_i,
  output logic signed [lfe_pkg::AngW-1:0]    angle_o
);

  localparam int DW = lfe_pkg::DiffW;
  localparam int CW = lfe_pkg::CordW;
  localparam int ZW = lfe_pkg::ZW;
  localparam int NI = lfe_pkg::CordicIters;

  logic [DW-1:0]        mx, my, mo;
  logic [5:0]           pos;
  logic [5:0]           k_q;
  logic signed [DW-1:0] x0_q, y0_q;
  logic signed [CW-1:0] xs_q, ys_q;

  always_comb begin
    mx  = x_i[DW-1] ? DW'(-x_i) : DW'(x_i);
    my  = y_i[DW-1] ? DW'(-y_i) : DW'(y_i);
    mo  = mx | my;
    pos = '0;
    for (int i = 0; i < DW; i++) begin
      if (mo[i]) pos = 6'(i);
    end
  end

  logic signed [CW-1:0] xi_q [NI+1];
  logic signed [CW-1:0] yi_q [NI+1];
  logic signed [ZW-1:0] zi_q [NI+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q  <= 6'd39 - pos;
      x0_q <= x_i;
      y0_q <= y_i;
      xs_q <= CW'(x0_q) <<< k_q;
      ys_q <= CW'(y0_q) <<< k_q;
      if (xs_q < 0) begin
        if (ys_q >= 0) begin
          xi_q[0] <= ys_q;
          yi_q[0] <= -xs_q;
          zi_q[0] <= lfe_pkg::PiHalfQ30;
        end else begin
          xi_q[0] <= -ys_q;
          yi_q[0] <= xs_q;
          zi_q[0] <= -lfe_pkg::PiHalfQ30;
        end
      end else begin
        xi_q[0] <= xs_q;
        yi_q[0] <= ys_q;
        zi_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_iter
    logic signed [ZW-1:0] at;
    assign at = $signed({4'b0, lfe_pkg::atan_q30(i)});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi_q[i] > 0) begin
          xi_q[i+1] <= xi_q[i] + (yi_q[i] >>> i);
          yi_q[i+1] <= yi_q[i] - (xi_q[i] >>> i);
          zi_q[i+1] <= zi_q[i] + at;
        end else begin
          xi_q[i+1] <= xi_q[i] - (yi_q[i] >>> i);
          yi_q[i+1] <= yi_q[i] + (xi_q[i] >>> i);
          zi_q[i+1] <= zi_q[i] - at;
        end
      end
    end
  end

  logic signed [ZW-1:0]                zr;
  logic signed [lfe_pkg::AngW-1:0]     ang_q;

  assign zr = (zi_q[NI] + (ZW'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= zr[lfe_pkg::AngW-1:0];
    end
  end

  assign angle_o = ang_q;

endmodule

>>> rtl/core/lfe_wrap.sv
// Pipelined heading difference reduced into minus pi to pi.
module lfe_wrap #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [15:0]              hd_i,
  input  logic signed [lfe_pkg::AngW-1:0] ang_i,
  output logic signed [15:0]              err_o
);

  localparam int W   = 22;
  localparam int PiQ = lfe_pkg::pi_q(ANGLE_FRAC_BITS);
  localparam int M   = 2 * PiQ;
  localparam int KS  = lfe_pkg::wrap_ks(ANGLE_FRAC_BITS);
  localparam int NR  = KS + 2;
  localparam logic [W-1:0] PiC  = W'(PiQ);
  localparam logic [W-1:0] ModC = W'(M);
  localparam logic [W-1:0] OffC = W'(M) << KS;

  logic [W-1:0] u_q [NR+1];
  logic [W-1:0] u_d;

  assign u_d = W'(hd_i) - W'(ang_i) + PiC + OffC;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0] <= u_d;
    end
  end

  for (genvar j = 0; j < NR; j++) begin : g_red
    logic [W-1:0] sub;
    assign sub = ModC << (KS + 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q[j+1] <= (u_q[j] >= sub) ? u_q[j] - sub : u_q[j];
      end
    end
  end

  logic signed [W-1:0] e;
  logic signed [15:0]  err_q;

  assign e = $signed(u_q[NR] - PiC);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (e > 22'sd32767) err_q <= 16'sh7FFF;
      else if (e < -22'sd32768) err_q <= 16'sh8000;
      else err_q <= e[15:0];
    end
  end

  assign err_o = err_q;

endmodule

>>> rtl/core/line_following_error.sv
// Top level of the line following error block: cross-track, along-track and heading error.
// Fully pipelined: one item per cycle while the output is taken. The result path runs through
// the 33-stage square root for the segment length followed by the 36-stage saturating
// dividers; the heading path (34-stage CORDIC and the modular wrap) runs alongside. When the
// output is not taken, the whole pipeline holds and in_ready_o drops.
module line_following_error #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfe_pkg::lfe_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lfe_pkg::lfe_out_t out_data_o
);

  localparam int DW      = lfe_pkg::DiffW;
  localparam int PW      = lfe_pkg::ProdW;
  localparam int SW      = lfe_pkg::SumW;
  localparam int Depth   = 73;
  localparam int LW      = lfe_pkg::wrap_ks(ANGLE_FRAC_BITS) + 4;
  localparam int HdDly   = 34;
  localparam int NumDly  = 33;
  localparam int DgDly   = 71;
  localparam int HeDly   = 37 - LW;
  localparam int PiQ     = lfe_pkg::pi_q(ANGLE_FRAC_BITS);
  localparam int HeadMax = (PiQ - 1 > 32767) ? 32767 : PiQ - 1;
  localparam int HeadMin = (-PiQ < -32768) ? -32768 : -PiQ;

  logic en;
  logic [Depth-1:0] vld_q;

  assign en          = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [15:0]   hd_q;
  logic                 dg_q;
  logic signed [PW-1:0] pxx_q, pyy_q, pxb_q, pyb_q, pxc_q, pyc_q;
  logic [PW-1:0]        len2_q;
  logic signed [SW-1:0] dot_q, crs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= $signed({in_data_i.goal_x[31], in_data_i.goal_x})
              - $signed({in_data_i.start_x[31], in_data_i.start_x});
      ay_q   <= $signed({in_data_i.goal_y[31], in_data_i.goal_y})
              - $signed({in_data_i.start_y[31], in_data_i.start_y});
      bx_q   <= $signed({in_data_i.goal_x[31], in_data_i.goal_x})
              - $signed({in_data_i.robot_x[31], in_data_i.robot_x});
      by_q   <= $signed({in_data_i.goal_y[31], in_data_i.goal_y})
              - $signed({in_data_i.robot_y[31], in_data_i.robot_y});
      cx_q   <= $signed({in_data_i.robot_x[31], in_data_i.robot_x})
              - $signed({in_data_i.start_x[31], in_data_i.start_x});
      cy_q   <= $signed({in_data_i.robot_y[31], in_data_i.robot_y})
              - $signed({in_data_i.start_y[31], in_data_i.start_y});
      hd_q   <= in_data_i.robot_heading;
      dg_q   <= (in_data_i.goal_x == in_data_i.start_x && in_data_i.goal_y == in_data_i.start_y)
             || (in_data_i.goal_x == in_data_i.robot_x && in_data_i.goal_y == in_data_i.robot_y);
      pxx_q  <= ax_q * ax_q;
      pyy_q  <= ay_q * ay_q;
      pxb_q  <= ax_q * bx_q;
      pyb_q  <= ay_q * by_q;
      pxc_q  <= ax_q * cy_q;
      pyc_q  <= ay_q * cx_q;
      len2_q <= $unsigned(pxx_q) + $unsigned(pyy_q);
      dot_q  <= SW'(pxb_q) + SW'(pyb_q);
      crs_q  <= SW'(pxc_q) - SW'(pyc_q);
    end
  end

  logic signed [15:0]   hd_dly_q  [HdDly];
  logic signed [SW-1:0] dot_dly_q [NumDly];
  logic signed [SW-1:0] crs_dly_q [NumDly];
  logic                 dg_dly_q  [DgDly];
  logic signed [15:0]   he_dly_q  [HeDly];
  logic signed [15:0]   herr;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hd_dly_q[0]  <= hd_q;
      dot_dly_q[0] <= dot_q;
      crs_dly_q[0] <= crs_q;
      dg_dly_q[0]  <= dg_q;
      he_dly_q[0]  <= herr;
      for (int i = 1; i < HdDly; i++) hd_dly_q[i] <= hd_dly_q[i-1];
      for (int i = 1; i < NumDly; i++) begin
        dot_dly_q[i] <= dot_dly_q[i-1];
        crs_dly_q[i] <= crs_dly_q[i-1];
      end
      for (int i = 1; i < DgDly; i++) dg_dly_q[i] <= dg_dly_q[i-1];
      for (int i = 1; i < HeDly; i++) he_dly_q[i] <= he_dly_q[i-1];
    end
  end

  logic [lfe_pkg::RootW-1:0]        len;
  logic signed [lfe_pkg::AngW-1:0]  ang;
  logic signed [31:0]               along, lateral;

  lfe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (len2_q),
    .root_o (len)
  );

  lfe_div u_div_along (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (dot_dly_q[NumDly-1]),
    .d_i   (len),
    .q_o   (along)
  );

  lfe_div u_div_lateral (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (crs_dly_q[NumDly-1]),
    .d_i   (len),
    .q_o   (lateral)
  );

  lfe_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (ax_q),
    .y_i     (ay_q),
    .angle_o (ang)
  );

  lfe_wrap #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_wrap (
    .clk_i (clk_i),
    .en_i  (en),
    .hd_i  (hd_dly_q[HdDly-1]),
    .ang_i (ang),
    .err_o (herr)
  );

  lfe_pkg::lfe_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dg_dly_q[DgDly-1]) begin
        out_q.along_error   <= '0;
        out_q.lateral_error <= '0;
        out_q.heading_error <= '0;
        out_q.degenerate    <= 1'b1;
      end else begin
        out_q.along_error   <= along;
        out_q.lateral_error <= lateral;
        out_q.heading_error <= he_dly_q[HeDly-1];
        out_q.degenerate    <= 1'b0;
      end
    end
  end

  assign out_data_o = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.along_error == 0 && out_data_o.lateral_error == 0
      && out_data_o.heading_error == 0)
    else $error("degenerate result carries nonzero fields");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(out_data_o.heading_error) <= HeadMax
      && $signed(out_data_o.heading_error) >= HeadMin)
    else $error("heading error outside wrap range");

  a_take_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transfer not captured");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

>>> tb/line_following_error_tb.sv
// Testbench for line_following_error: directed and random pose items checked against a predictor.
`timescale 1ns / 1ps

module line_following_error_tb;

  localparam int AngFrac = 13;
  localparam int Latency = 73;
  localparam longint CycleLimit = 3000000;
  localparam longint PiQ30Val = 64'sd3373259426;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  lfe_pkg::lfe_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  lfe_pkg::lfe_out_t out_data_o;

  lfe_pkg::lfe_out_t expected_q[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  int       mismatches = 0;
  longint   cycles = 0;

  longint   atan_tab[30] = '{
    843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  line_following_error #(.ANGLE_FRAC_BITS(AngFrac)) uut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint pi_scaled();
    return (PiQ30Val + (64'sd1 <<< (29 - AngFrac))) >>> (30 - AngFrac);
  endfunction

  function automatic logic signed [31:0] clamp_quot(logic signed [127:0] num, longint den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic longint segment_heading(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    while ((x < 0 ? -x : x) < (64'sd1 <<< 39) && (y < 0 ? -y : y) < (64'sd1 <<< 39)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = PiQ30Val / 2;
      end else begin
        t = -y; y = x; x = t; z = -(PiQ30Val / 2);
      end
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return (z + (64'sd1 <<< (29 - AngFrac))) >>> (30 - AngFrac);
  endfunction

  function automatic lfe_pkg::lfe_out_t track_error(lfe_pkg::lfe_in_t p);
    lfe_pkg::lfe_out_t r;
    longint ax, ay, bx, by, cx, cy, root, cand, e, m;
    logic signed [127:0] sq, dot, crs;
    ax = longint'(p.goal_x) - longint'(p.start_x);
    ay = longint'(p.goal_y) - longint'(p.start_y);
    bx = longint'(p.goal_x) - longint'(p.robot_x);
    by = longint'(p.goal_y) - longint'(p.robot_y);
    cx = longint'(p.robot_x) - longint'(p.start_x);
    cy = longint'(p.robot_y) - longint'(p.start_y);
    r = '0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      r.degenerate = 1'b1;
      return r;
    end
    sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (64'sd1 <<< b);
      if (128'(cand) * 128'(cand) <= sq) root = cand;
    end
    dot = 128'(ax) * 128'(bx) + 128'(ay) * 128'(by);
    crs = 128'(ax) * 128'(cy) - 128'(ay) * 128'(cx);
    r.along_error = clamp_quot(dot, root);
    r.lateral_error = clamp_quot(crs, root);
    m = 2 * pi_scaled();
    e = (longint'(p.robot_heading) - segment_heading(ax, ay) + pi_scaled()) % m;
    if (e < 0) e += m;
    e -= pi_scaled();
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    r.heading_error = e[15:0];
    return r;
  endfunction

  task automatic send_pose(lfe_pkg::lfe_in_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(track_error(p));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic lfe_pkg::lfe_in_t rand_pose();
    lfe_pkg::lfe_in_t p;
    int sel;
    p.start_x = rand_coord();
    p.start_y = rand_coord();
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      p.goal_x = rand_coord();
      p.goal_y = rand_coord();
    end else begin
      p.goal_x = p.start_x + ($signed($urandom_range(0, 1 << (4 * sel + 8))) - (1 << (4 * sel + 7)));
      p.goal_y = p.start_y + ($signed($urandom_range(0, 1 << (4 * sel + 8))) - (1 << (4 * sel + 7)));
    end
    if ($urandom_range(0, 1)) begin
      p.robot_x = rand_coord();
      p.robot_y = rand_coord();
    end else begin
      p.robot_x = p.start_x + ($signed($urandom_range(0, 65535)) - 32768);
      p.robot_y = p.start_y + ($signed($urandom_range(0, 65535)) - 32768);
    end
    case ($urandom_range(0, 19))
      0: begin p.goal_x = p.start_x; p.goal_y = p.start_y; end
      1: begin p.robot_x = p.goal_x; p.robot_y = p.goal_y; end
      default: ;
    endcase
    p.robot_heading = $urandom_range(0, 9) == 0 ? 16'($urandom())
                                                : 16'($signed($urandom_range(0, 51472)) - 25736);
    return p;
  endfunction

  function automatic lfe_pkg::lfe_in_t make_pose(int rx, int ry, int hd, int sx, int sy,
                                                 int gx, int gy);
    lfe_pkg::lfe_in_t p;
    p.robot_x = rx; p.robot_y = ry; p.robot_heading = 16'(hd);
    p.start_x = sx; p.start_y = sy; p.goal_x = gx; p.goal_y = gy;
    return p;
  endfunction

  task automatic test_directed();
    int mn, mx;
    mn = 32'h80000000;
    mx = 32'h7fffffff;
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(5, 5, 0, 0, 0, 5, 5));
    send_pose(make_pose(0, 65536, 100, 0, 0, 65536, 0));
    send_pose(make_pose(0, -65536, -100, 0, 0, 65536, 0));
    send_pose(make_pose(0, 0, 25736, 0, 0, -65536, 0));
    send_pose(make_pose(0, 0, -25736, 0, 0, 0, -65536));
    send_pose(make_pose(0, 0, 0, 0, 0, -65536, -1));
    send_pose(make_pose(0, 0, 0, 0, 0, -65536, 1));
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 65536));
    send_pose(make_pose(0, 0, 32767, 0, 0, 1, 1));
    send_pose(make_pose(0, 0, -32768, 0, 0, 1, -1));
    send_pose(make_pose(mx, mx, 0, mn, mn, mx, mn));
    send_pose(make_pose(mn, mx, 0, mn, mn, mx, mx));
    send_pose(make_pose(mn, mn, 0, mn, mn, mx, mx));
    send_pose(make_pose(mx, mn, 0, mx, mx, mn, mn));
    send_pose(make_pose(mx, mx, 0, mn, mx, mn + 1, mx));
    send_pose(make_pose(mn, mn, 0, 0, 0, 1, 0));
    send_pose(make_pose(mx, mn, 0, 0, 0, 0, 1));
    send_pose(make_pose(-1, -1, -1, -1, -1, 0, 0));
    send_pose(make_pose(mx, mx, 12345, mx, mx, mx, mx));
    drain();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_pose(rand_pose());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 300;
    repeat (150) send_pose(rand_pose());
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    lfe_pkg::lfe_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer out: %p", out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.along_error !== want.along_error ||
            out_data_o.lateral_error !== want.lateral_error ||
            out_data_o.heading_error !== want.heading_error ||
            out_data_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("line_following_error verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 0, 0);
    test_random(400, 86, 0);
    test_random(400, 0, 86);
    test_random(450, 10, 10);
    test_backpressure();
    repeat (Latency + 30) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("line_following_error verification clean");
    end else begin
      $display("line_following_error verification failed");
    end
    $finish;
  end

endmodule
